/* rtl/core/lbau_pkg.sv */
// Shared constants, codes and types for the limb-serial bignum unit.
// No dependencies; imported by every module of the block.
package lbau_pkg;

  localparam int LIMB_COUNT = 8;
  localparam int LIMB_AW    = (LIMB_COUNT > 1) ? $clog2(LIMB_COUNT) : 1;
  localparam int COL_COUNT  = 2 * LIMB_COUNT;
  localparam int COL_AW     = $clog2(COL_COUNT);

  localparam int LIMB_W = 32;
  localparam int WORD_W = 36;
  localparam int SUM_W  = WORD_W + 2;
  localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};

  // stream widths
  localparam int KIND_W     = 3;
  localparam int IDX_W      = 3;
  localparam int POS_W      = 4;
  localparam int SRC_W      = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  // input kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_A = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SQR    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CSUB   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CSWAP  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CMOV   = 3'd6;

  // result sources
  localparam logic [SRC_W-1:0] SRC_COL = 2'd0;
  localparam logic [SRC_W-1:0] SRC_A   = 2'd1;
  localparam logic [SRC_W-1:0] SRC_B   = 2'd2;
  localparam logic [SRC_W-1:0] SRC_BAD = 2'd3;

  // column store control
  typedef struct packed {
    logic              clear;   // invalidate all columns (reads as zero)
    logic              acc_en;  // saturating add of two addends at addr
    logic              load_en; // plain write of addend a at addr
    logic [COL_AW-1:0] addr;
  } col_ctl_t;

endpackage

/* rtl/core/limb_bignum_arith_unit.sv */
// Limb-serial bignum unit: operand store, shared 32x32 multiplier, sequencer.
// Depends on lbau_pkg and lbau_colacc.
// Loads take one limb and give no result. Multiply/square: per row one operand fetch,
//   a multiply and an accumulate per product and one high-half write (L = LIMB_COUNT),
//   then 2*L column words.
// Cond subtract: L borrow steps, then L words; cmov L words; cswap 2*L words.
// Not ready until the last word of an operation is in the output register.
// Sync reset: operands zeroed, column store invalidated, output emptied.
module limb_bignum_arith_unit import lbau_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // limb_index[2:0], limb_value[34:3], flag[35]
  input  logic [KIND_W-1:0]     s_tuser,  // kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // position[3:0], word[39:4]
  output logic [SRC_W-1:0]      m_tuser,  // source
  output logic                  m_tlast
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ROW    = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_ACC    = 3'd3;
  localparam logic [2:0] S_ROWEND = 3'd4;
  localparam logic [2:0] S_SUB    = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state;

  // operand limbs, each array read at one address per cycle
  logic [LIMB_W-1:0] opa [LIMB_COUNT];
  logic [LIMB_W-1:0] opb [LIMB_COUNT];

  logic [KIND_W-1:0] op;
  logic              flag;
  logic              take;     // cond subtract result goes to A
  logic              borrow;
  logic              phase;    // cswap: 0 emits A, 1 emits B
  logic [COL_AW-1:0] ci;
  logic [LIMB_AW-1:0] cj;
  logic [LIMB_W-1:0] xr;
  logic [LIMB_W-1:0] hi_prev;
  logic [2*LIMB_W-1:0] prod;

  // input unpack
  logic              accept;
  logic [IDX_W-1:0]  in_idx;
  logic [LIMB_W-1:0] in_val;
  logic              in_flag;
  logic              in_idx_ok;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign in_idx    = s_tdata[IDX_W-1:0];
  assign in_val    = s_tdata[IDX_W +: LIMB_W];
  assign in_flag   = s_tdata[IDX_W+LIMB_W];
  assign in_idx_ok = (32'(in_idx) < LIMB_COUNT);

  // operand read ports; square reads A on the column side too
  logic [LIMB_AW-1:0] a_addr, b_addr;
  logic [LIMB_W-1:0]  a_rd, b_rd;

  assign a_addr = (state == S_MUL && op == KIND_SQR) ? cj : ci[LIMB_AW-1:0];
  assign b_addr = (state == S_MUL) ? cj : ci[LIMB_AW-1:0];
  assign a_rd   = opa[a_addr];
  assign b_rd   = opb[b_addr];

  // borrow chain step for cond subtract
  logic [LIMB_W:0] sub_full;
  assign sub_full = {1'b0, a_rd} - {1'b0, b_rd} - (LIMB_W+1)'(borrow);

  // column store
  col_ctl_t          col_ctl;
  logic [LIMB_W-1:0] col_a, col_b;
  logic [WORD_W-1:0] col_rd;

  always_comb begin
    col_ctl.clear   = accept && (s_tuser == KIND_MUL || s_tuser == KIND_SQR);
    col_ctl.acc_en  = (state == S_ACC) || (state == S_ROWEND);
    col_ctl.load_en = (state == S_SUB);
    unique case (state)
      S_ACC:    col_ctl.addr = ci + COL_AW'(cj);
      S_ROWEND: col_ctl.addr = ci + COL_AW'(LIMB_COUNT);
      default:  col_ctl.addr = ci;
    endcase
    col_a = hi_prev;
    col_b = '0;
    if (state == S_ACC) begin
      col_a = prod[LIMB_W-1:0];
      col_b = hi_prev;
    end else if (state == S_SUB) begin
      col_a = sub_full[LIMB_W-1:0];
    end
  end

  lbau_colacc u_colacc (
    .clk     (clk),
    .rst     (rst),
    .ctl     (col_ctl),
    .add_a   (col_a),
    .add_b   (col_b),
    .rd_data (col_rd)
  );

  // result word selection
  logic              out_free, emit_go, is_mul;
  logic              limb_end, col_end, emit_last;
  logic [LIMB_W-1:0] emit_limb;
  logic [WORD_W-1:0] emit_word;
  logic [SRC_W-1:0]  emit_src;

  assign out_free = !m_tvalid || m_tready;
  assign emit_go  = (state == S_EMIT) && out_free;
  assign is_mul   = (op == KIND_MUL) || (op == KIND_SQR);
  assign limb_end = (ci == COL_AW'(LIMB_COUNT - 1));
  assign col_end  = (ci == COL_AW'(COL_COUNT - 1));

  always_comb begin
    case (op)
      KIND_CSUB:  emit_limb = take ? col_rd[LIMB_W-1:0] : a_rd;
      KIND_CSWAP: emit_limb = (phase || flag) ? b_rd : a_rd;
      default:    emit_limb = flag ? b_rd : a_rd;
    endcase
    emit_word = is_mul ? col_rd : WORD_W'(emit_limb);
    if (is_mul) begin
      emit_src  = SRC_COL;
      emit_last = col_end;
    end else if (op == KIND_CSWAP) begin
      emit_src  = phase ? SRC_B : SRC_A;
      emit_last = phase && limb_end;
    end else begin
      emit_src  = SRC_A;
      emit_last = limb_end;
    end
  end

  // sequencer, operand writes, output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      for (int k = 0; k < LIMB_COUNT; k++) begin
        opa[k] <= '0;
        opb[k] <= '0;
      end
    end else begin
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (s_tuser)
              KIND_LOAD_A: if (in_idx_ok) opa[LIMB_AW'(in_idx)] <= in_val;
              KIND_LOAD_B: if (in_idx_ok) opb[LIMB_AW'(in_idx)] <= in_val;
              KIND_MUL, KIND_SQR: state <= S_ROW;
              KIND_CSUB: state <= S_SUB;
              KIND_CSWAP, KIND_CMOV: state <= S_EMIT;
              default: ;
            endcase
          end
        end
        S_ROW:  state <= S_MUL;
        S_MUL:  state <= S_ACC;
        S_ACC:  state <= (cj == LIMB_AW'(LIMB_COUNT - 1)) ? S_ROWEND : S_MUL;
        S_ROWEND: state <= limb_end ? S_EMIT : S_ROW;
        S_SUB:  if (limb_end) state <= S_EMIT;
        S_EMIT: begin
          if (emit_go) begin
            case (op)
              KIND_CSUB: if (take) opa[ci[LIMB_AW-1:0]] <= emit_limb;
              KIND_CMOV: if (flag) opa[ci[LIMB_AW-1:0]] <= b_rd;
              KIND_CSWAP: begin
                if (flag && !phase) begin
                  opa[ci[LIMB_AW-1:0]] <= b_rd;
                  opb[ci[LIMB_AW-1:0]] <= a_rd;
                end
              end
              default: ;
            endcase
            if (emit_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op     <= s_tuser;
          flag   <= in_flag;
          ci     <= '0;
          borrow <= 1'b0;
          phase  <= 1'b0;
        end
      end
      S_ROW: begin
        xr      <= a_rd;
        hi_prev <= '0;
        cj      <= '0;
      end
      S_MUL: prod <= (2*LIMB_W)'(xr) * (2*LIMB_W)'(a_addr == cj && op == KIND_SQR ?
                                                     a_rd : b_rd);
      S_ACC: begin
        hi_prev <= prod[2*LIMB_W-1:LIMB_W];
        cj      <= cj + 1'b1;
      end
      S_ROWEND: ci <= limb_end ? '0 : ci + 1'b1;
      S_SUB: begin
        borrow <= sub_full[LIMB_W];
        if (limb_end) begin
          // take when flag is set or A >= B, i.e. the chain does not borrow out
          take <= flag || !sub_full[LIMB_W];
          ci   <= '0;
        end else begin
          ci <= ci + 1'b1;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          if (op == KIND_CSWAP && !phase && limb_end) begin
            phase <= 1'b1;
            ci    <= '0;
          end else begin
            ci <= ci + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit_go) begin
      m_tdata <= {emit_word, POS_W'(ci)};
      m_tuser <= emit_src;
      m_tlast <= emit_last;
    end
  end

endmodule

/* rtl/core/lbau_colacc.sv */
// Column-sum store with a saturating accumulate port.
// Depends on lbau_pkg.
module lbau_colacc import lbau_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  col_ctl_t          ctl,
  input  logic [LIMB_W-1:0] add_a,
  input  logic [LIMB_W-1:0] add_b,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0]    cols [COL_COUNT];
  logic [COL_COUNT-1:0] valid;
  logic [SUM_W-1:0]     sum;
  logic [WORD_W-1:0]    sat_sum;

  // unwritten columns read as zero
  assign rd_data = valid[ctl.addr] ? cols[ctl.addr] : '0;

  assign sum     = SUM_W'(rd_data) + SUM_W'(add_a) + SUM_W'(add_b);
  assign sat_sum = (sum > SUM_W'(WORD_MAX)) ? WORD_MAX : sum[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.clear) begin
      valid <= '0;
    end else if (ctl.acc_en || ctl.load_en) begin
      valid[ctl.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      cols[ctl.addr] <= sat_sum;
    end else if (ctl.load_en) begin
      cols[ctl.addr] <= WORD_W'(add_a);
    end
  end

endmodule

/* rtl/core/lbau_checker.sv */
// Port-level checks for the limb-serial bignum unit, bound to the top level.
// Depends on lbau_pkg and limb_bignum_arith_unit.
module lbau_checker import lbau_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic [KIND_W-1:0]     s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [SRC_W-1:0]      m_tuser,
  input logic                  m_tlast
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output word changed");

  // no new input while a run is still being delivered
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken in the middle of a run");

  // source code is never the unused one
  a_src: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != SRC_BAD)
    else $error("bad source code");

  // limb words carry only 32 significant bits
  a_limb: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != SRC_COL |-> m_tdata[OUT_DATA_W-1:OUT_DATA_W-4] == 4'd0)
    else $error("limb word wider than 32 bits");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind limb_bignum_arith_unit lbau_checker u_lbau_checker (.*);
